// File: rtl/tlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_pkg: shared types and constants of the text line folder
// Character codes, operation codes and the classified request that travels
// from the front part through the queue to the fold engine.
// ----------------------------------------------------------------------------
package tlf_pkg;

    localparam int CHAR_W  = 8;
    localparam int LW_W    = 6;

    localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SP  = 8'd32;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;

    localparam logic OP_CHAR  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [LW_W-1:0] LINE_WIDTH_RST = 6'd32;

    // queue between front and engine: two entries
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;
    localparam logic [QCNT_W-1:0] QDEPTH = 2'd2;

    typedef struct packed {
        logic              flush;
        logic              newline;
        logic              blank;
        logic [CHAR_W-1:0] ch;
    } tlf_req_t;

endpackage

// File: rtl/tlf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_front: request intake and classification
// Accepts requests from the input channel, tags them as flush, newline or
// blank, and holds one classified request until the queue takes it.
// ----------------------------------------------------------------------------
module tlf_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_operation,
    input  logic [tlf_pkg::CHAR_W-1:0] s_in_char,
    output logic                      req_valid,
    input  logic                      req_ready,
    output tlf_pkg::tlf_req_t         req
);

    logic              vld_reg;
    tlf_pkg::tlf_req_t req_reg;
    tlf_pkg::tlf_req_t req_next;

    assign s_ready   = !vld_reg || req_ready;
    assign req_valid = vld_reg;
    assign req       = req_reg;

    // classify the incoming request
    always_comb begin
        req_next.flush   = (s_operation == tlf_pkg::OP_FLUSH);
        req_next.newline = (s_in_char == tlf_pkg::CH_NL);
        req_next.blank   = (s_in_char == tlf_pkg::CH_SP) || (s_in_char == tlf_pkg::CH_TAB);
        req_next.ch      = s_in_char;
    end

    // hold one request until the queue takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            vld_reg <= 1'b1;
        end else if (req_ready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= req_next;
        end
    end

endmodule

// File: rtl/tlf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_queue: two-entry request queue
// Decouples the intake from the fold engine so that each side stalls on
// its own.
// ----------------------------------------------------------------------------
module tlf_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  tlf_pkg::tlf_req_t in_req,
    output logic              out_valid,
    input  logic              out_ready,
    output tlf_pkg::tlf_req_t out_req
);

    tlf_pkg::tlf_req_t                 slot_reg [2];
    logic [tlf_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [tlf_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [tlf_pkg::QCNT_W-1:0]        cnt_reg;
    logic                              push;
    logic                              pop;

    assign in_ready  = (cnt_reg != tlf_pkg::QDEPTH);
    assign out_valid = (cnt_reg != '0);
    assign out_req   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_req;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= tlf_pkg::QDEPTH)
        else $error("queue occupancy beyond depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |=> !pop || $past(push))
        else $error("queue popped while empty");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == tlf_pkg::QDEPTH) || (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with occupancy");

endmodule

// File: rtl/tlf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_back: fold engine
// Stores characters in the line buffer and tracks the last blank. On a full
// line, an early newline or a flush it emits the buffered text; on a full
// line with a blank it adds the folding newline and moves the rest forward.
// ----------------------------------------------------------------------------
module tlf_back #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [tlf_pkg::LW_W-1:0]   line_width,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  tlf_pkg::tlf_req_t          req,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [tlf_pkg::CHAR_W-1:0] m_out_char,
    output logic                       m_last
);

    localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);
    localparam logic [CNT_W-1:0]         MAX_CNT = CNT_W'(MAX_WIDTH);
    localparam logic [IDX_W-1:0]         TOP_IDX = IDX_W'(MAX_WIDTH - 1);
    localparam logic [tlf_pkg::LW_W:0]   MAX_LW  = (tlf_pkg::LW_W + 1)'(MAX_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_OUT,
        S_NL,
        S_MV_RD,
        S_MV_WR
    } state_t;

    state_t                      state_reg;
    logic [CNT_W-1:0]            fill_reg;
    logic                        blank_vld_reg;
    logic [IDX_W-1:0]            blank_pos_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [IDX_W-1:0]            end_reg;
    logic [IDX_W-1:0]            src_reg;
    logic                        fold_reg;
    logic                        m_valid_reg;
    logic [tlf_pkg::CHAR_W-1:0]  m_out_char_reg;
    logic                        m_last_reg;

    logic [tlf_pkg::CHAR_W-1:0]  mem [MAX_WIDTH];
    logic [tlf_pkg::CHAR_W-1:0]  mem_q;

    logic                        pop;
    logic                        out_load;
    logic                        out_fire;
    logic [CNT_W-1:0]            eff_w;
    logic [IDX_W-1:0]            wp;
    logic [CNT_W-1:0]            new_fill;
    logic                        found;
    logic [IDX_W-1:0]            blank_pos_next;
    logic [CNT_W-1:0]            rest;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    logic [tlf_pkg::CHAR_W-1:0]  wr_data;
    logic [IDX_W-1:0]            rd_addr;

    assign req_ready  = (state_reg == S_IDLE);
    assign pop        = req_valid && req_ready;
    assign out_load   = !m_valid_reg || m_ready;
    assign out_fire   = ((state_reg == S_OUT) || (state_reg == S_NL)) && out_load;
    assign m_valid    = m_valid_reg;
    assign m_out_char = m_out_char_reg;
    assign m_last     = m_last_reg;

    // clamp the configured width into one to MAX_WIDTH
    always_comb begin
        if (line_width == '0) begin
            eff_w = CNT_W'(1);
        end else if ({1'b0, line_width} > MAX_LW) begin
            eff_w = MAX_CNT;
        end else begin
            eff_w = CNT_W'(line_width);
        end
    end

    // write slot, new fill and last blank including the arriving character
    always_comb begin
        wp             = (fill_reg >= MAX_CNT) ? TOP_IDX : fill_reg[IDX_W-1:0];
        new_fill       = CNT_W'(wp) + CNT_W'(1);
        found          = req.blank || blank_vld_reg;
        blank_pos_next = req.blank ? wp : blank_pos_reg;
        rest           = fill_reg - (CNT_W'(end_reg) + CNT_W'(1));
    end

    // buffer port selection
    always_comb begin
        wr_en   = (pop && !req.flush) || (state_reg == S_MV_WR);
        wr_addr = (state_reg == S_MV_WR) ? idx_reg : wp;
        wr_data = (state_reg == S_MV_WR) ? mem_q : req.ch;
        rd_addr = (state_reg == S_MV_RD) ? src_reg : idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        mem_q <= mem[rd_addr];
    end

    // sequence storing, emission and remainder move
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            blank_vld_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // hold a result until it is taken, load the next in its place
            if (out_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (pop) begin
                        idx_reg <= '0;
                        if (req.flush) begin
                            fold_reg <= 1'b0;
                            end_reg  <= IDX_W'(fill_reg - CNT_W'(1));
                            if (fill_reg != '0) begin
                                state_reg <= S_RD;
                            end
                        end else begin
                            fill_reg      <= new_fill;
                            blank_vld_reg <= found;
                            blank_pos_reg <= blank_pos_next;
                            if (new_fill < eff_w) begin
                                fold_reg <= 1'b0;
                                end_reg  <= wp;
                                if (req.newline) begin
                                    state_reg <= S_RD;
                                end
                            end else if (found) begin
                                fold_reg  <= 1'b1;
                                end_reg   <= blank_pos_next;
                                state_reg <= S_RD;
                            end else begin
                                fold_reg  <= 1'b0;
                                end_reg   <= wp;
                                state_reg <= S_RD;
                            end
                        end
                    end
                end
                S_RD: begin
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        m_out_char_reg <= mem_q;
                        m_last_reg     <= (idx_reg == end_reg) && !fold_reg;
                        if (idx_reg != end_reg) begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= S_RD;
                        end else if (fold_reg) begin
                            state_reg <= S_NL;
                        end else begin
                            fill_reg      <= '0;
                            blank_vld_reg <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                S_NL: begin
                    if (out_load) begin
                        m_out_char_reg <= tlf_pkg::CH_NL;
                        m_last_reg     <= 1'b1;
                        fill_reg       <= rest;
                        blank_vld_reg  <= 1'b0;
                        idx_reg        <= '0;
                        src_reg        <= end_reg + IDX_W'(1);
                        state_reg      <= (rest == '0) ? S_IDLE : S_MV_RD;
                    end
                end
                S_MV_RD: begin
                    state_reg <= S_MV_WR;
                end
                S_MV_WR: begin
                    if (CNT_W'(idx_reg) + CNT_W'(1) == fill_reg) begin
                        state_reg <= S_IDLE;
                    end else begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        src_reg   <= src_reg + IDX_W'(1);
                        state_reg <= S_MV_RD;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= MAX_CNT)
        else $error("fill count beyond buffer depth");

    a_blank_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        blank_vld_reg && (state_reg == S_IDLE) |-> (CNT_W'(blank_pos_reg) < fill_reg))
        else $error("tracked blank outside the stored text");

    a_move_dest: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MV_WR) |-> (CNT_W'(idx_reg) < fill_reg) && (src_reg > idx_reg))
        else $error("remainder move out of range");

    a_nl_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_NL) && out_load |=>
            m_valid && m_last && ((state_reg == S_IDLE) || (state_reg == S_MV_RD)))
        else $error("folding newline not closing the run");

endmodule

// File: rtl/text_line_folder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_folder: word-wrap line folder
// Folds a byte stream into lines of at most line_width bytes, breaking
// after the last space or tab.
// ----------------------------------------------------------------------------
// Requests enter through a registered intake and a two-entry queue, so the
// input side keeps accepting while the queue has room and results wait on
// the output register. The fold engine works on one request at a time,
// bound by its single buffer memory with a registered read: a byte that
// produces no output is only stored, each emitted byte is read and then
// loaded into the output register, an inserted newline is loaded directly,
// and each byte of the remainder is read and then written to the front.
// Write cfg_data (the line width, 0 acting as 1 and values above MAX_WIDTH
// acting as MAX_WIDTH) only while no request is in flight; it resets to 32.
module text_line_folder #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [tlf_pkg::LW_W-1:0]   cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_operation,
    input  logic [tlf_pkg::CHAR_W-1:0] s_in_char,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [tlf_pkg::CHAR_W-1:0] m_out_char,
    output logic                       m_last
);

    logic [tlf_pkg::LW_W-1:0] line_width_reg;
    logic                     f_valid;
    logic                     f_ready;
    tlf_pkg::tlf_req_t        f_req;
    logic                     q_valid;
    logic                     q_ready;
    tlf_pkg::tlf_req_t        q_req;

    assign cfg_ready = 1'b1;

    // hold the line width register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= tlf_pkg::LINE_WIDTH_RST;
        end else if (cfg_valid && cfg_ready) begin
            line_width_reg <= cfg_data;
        end
    end

    tlf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_in_char   (s_in_char),
        .req_valid   (f_valid),
        .req_ready   (f_ready),
        .req         (f_req)
    );

    tlf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_req    (f_req),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_req   (q_req)
    );

    tlf_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .line_width (line_width_reg),
        .req_valid  (q_valid),
        .req_ready  (q_ready),
        .req        (q_req),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_last     (m_last)
    );

endmodule
